// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

  // Default sizing
  localparam int SLOTS_DEF      = 256;
  localparam int MAX_OBJ_DEF    = 4096;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int OFF_W  = 20;
  localparam int IDX_W  = 9;
  localparam int CNT_W  = 9;
  localparam int SIZE_W = 13;
  localparam int ST_W   = 3;

  // Bitmap word geometry
  localparam int WB     = 8;
  localparam int WB_W   = 3;

  // Register indexes of the configuration port
  localparam int unsigned REG_SLOT_COUNT  = 0;
  localparam int unsigned REG_OBJECT_SIZE = 1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_LIVE   = 3'd3;
  localparam logic [ST_W-1:0] ST_MISALIGNED = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic afind;
    logic apick;
    logic rmul;
    logic rchk;
    logic rdiv;
    logic rtest;
    logic rwr;
    logic clr;
    logic qfirst;
    logic qword;
    logic qnext;
    logic out_load;
  } bsa_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic a_cand;
    logic r_in_range;
    logic div_last;
    logic r_aligned;
    logic q_in_range;
    logic q_hit;
    logic q_more;
  } bsa_sts_t;

endpackage

// ===== rtl/bsa_ctrl.sv =====
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  bsa_sts_t         sts,
  output bsa_ctl_t         ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AFIND  = 4'd1;
  localparam logic [3:0] S_APICK  = 4'd2;
  localparam logic [3:0] S_RMUL   = 4'd3;
  localparam logic [3:0] S_RCHK   = 4'd4;
  localparam logic [3:0] S_RDIV   = 4'd5;
  localparam logic [3:0] S_RTEST  = 4'd6;
  localparam logic [3:0] S_RWR    = 4'd7;
  localparam logic [3:0] S_CLR    = 4'd8;
  localparam logic [3:0] S_QFIRST = 4'd9;
  localparam logic [3:0] S_QWORD  = 4'd10;
  localparam logic [3:0] S_QNEXT  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Sequence the datapath through one command
  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load = 1'b1;
          case (in_cmd)
            CMD_ALLOC:   state_nxt = S_AFIND;
            CMD_RELEASE: state_nxt = S_RMUL;
            CMD_CLEAR:   state_nxt = S_CLR;
            default:     state_nxt = S_QFIRST;
          endcase
        end
      end
      S_AFIND: begin
        ctl.afind = 1'b1;
        state_nxt = sts.a_cand ? S_APICK : S_DONE;
      end
      S_APICK: begin
        ctl.apick = 1'b1;
        state_nxt = S_DONE;
      end
      S_RMUL: begin
        ctl.rmul  = 1'b1;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        ctl.rchk  = 1'b1;
        state_nxt = sts.r_in_range ? S_RDIV : S_DONE;
      end
      S_RDIV: begin
        ctl.rdiv = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RTEST;
        end
      end
      S_RTEST: begin
        ctl.rtest = 1'b1;
        state_nxt = sts.r_aligned ? S_RWR : S_DONE;
      end
      S_RWR: begin
        ctl.rwr   = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        ctl.clr   = 1'b1;
        state_nxt = S_DONE;
      end
      S_QFIRST: begin
        ctl.qfirst = 1'b1;
        state_nxt  = sts.q_in_range ? S_QWORD : S_DONE;
      end
      S_QWORD: begin
        ctl.qword = 1'b1;
        state_nxt = (!sts.q_hit && sts.q_more) ? S_QNEXT : S_DONE;
      end
      S_QNEXT: begin
        ctl.qnext = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/bsa_dpath.sv =====
module bsa_dpath
  import bsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  bsa_ctl_t          ctl,
  output bsa_sts_t          sts,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [CNT_W-1:0]  n_slots,
  input  logic [SIZE_W-1:0] obj_size,
  output logic [ST_W-1:0]   out_status,
  output logic [OFF_W-1:0]  out_offset,
  output logic [CNT_W-1:0]  out_next,
  output logic [CNT_W-1:0]  out_live
);

  localparam int WORDS  = (SLOTS + WB - 1) / WB;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SI_W   = WA_W + WB_W;
  localparam int CNT_LW = $clog2(SLOTS + 1);
  localparam int CW     = ((SI_W > CNT_W) ? SI_W : CNT_W) + 1;
  localparam int MA_W   = (SI_W > CNT_W) ? SI_W : CNT_W;
  localparam int P_W    = MA_W + SIZE_W;
  localparam int DV_W   = (SIZE_W + SI_W > OFF_W) ? SIZE_W + SI_W : OFF_W;
  localparam int K_W    = $clog2(SI_W);

  // Lowest set bit of a bitmap word, with a found flag on top
  function automatic logic [WB_W:0] ffs_word(input logic [WB-1:0] v);
    logic [WB_W:0] r;
    r = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = {1'b1, WB_W'(b)};
      end
    end
    return r;
  endfunction

  logic [CMD_W-1:0]  cmd_r;
  logic [OFF_W-1:0]  off_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [CNT_W-1:0]  next_r, next_nxt;
  logic [P_W-1:0]    prod_r, prod_nxt;
  logic [OFF_W-1:0]  rem_r, rem_nxt;
  logic [SI_W-1:0]   q_r, q_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [CNT_LW-1:0] cnt_r, cnt_nxt;
  logic [WORDS-1:0]  any_r, any_nxt;
  logic [WORDS-1:0]  full_r, full_nxt;
  logic [WA_W-1:0]   addr_r;
  logic [WB-1:0]     rdata_r;
  logic [WB-1:0]     mem_r [WORDS];

  logic [ST_W-1:0]   out_status_r;
  logic [OFF_W-1:0]  out_offset_r;
  logic [CNT_W-1:0]  out_next_r;
  logic [CNT_W-1:0]  out_live_r;

  logic [CW-1:0]     n_ext;
  logic [CW-1:0]     s_ext;
  logic [WA_W-1:0]   s_word;
  logic [WB_W-1:0]   s_bit;
  logic [WB-1:0]     word_v;
  logic [WB-1:0]     in_pool;
  logic              a_found;
  logic [WA_W-1:0]   a_word;
  logic              q_found;
  logic [WA_W-1:0]   q_word;
  logic [WB_W:0]     pick;
  logic [WB-1:0]     pick_mask;
  logic [WB-1:0]     new_word;
  logic [SI_W-1:0]   slot;
  logic [MA_W-1:0]   mul_a;
  logic [DV_W-1:0]   div_d;
  logic [DV_W-1:0]   div_r;
  logic              rd_en;
  logic [WA_W-1:0]   rd_addr;
  logic              we;

  assign n_ext  = CW'(n_slots);
  assign s_ext  = CW'(idx_r) + CW'(1);
  assign s_word = s_ext[SI_W-1:WB_W];
  assign s_bit  = s_ext[WB_W-1:0];

  // A word whose live flag is clear reads as all free
  assign word_v = any_r[addr_r] ? rdata_r : '0;

  // Bits of the addressed word that fall below the slot count
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      in_pool[b] = CW'({addr_r, WB_W'(b)}) < n_ext;
    end
  end

  // First word with a free slot inside the pool
  always_comb begin
    a_found = 1'b0;
    a_word  = '0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (!full_r[w] && (CW'(w * WB) < n_ext)) begin
        a_found = 1'b1;
        a_word  = WA_W'(w);
      end
    end
  end

  // First live word past the query's starting word
  always_comb begin
    q_found = 1'b0;
    q_word  = '0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (any_r[w] && (WA_W'(w) > s_word) && (CW'(w * WB) < n_ext)) begin
        q_found = 1'b1;
        q_word  = WA_W'(w);
      end
    end
  end

  // Bit selection in the word that was just read
  always_comb begin
    pick_mask = '0;
    for (int b = 0; b < WB; b++) begin
      if (ctl.apick) begin
        pick_mask[b] = !word_v[b] && in_pool[b];
      end else if (ctl.qword) begin
        pick_mask[b] = word_v[b] && in_pool[b] && (WB_W'(b) >= s_bit);
      end else begin
        pick_mask[b] = word_v[b] && in_pool[b];
      end
    end
  end

  assign pick = ffs_word(pick_mask);
  assign slot = {addr_r, pick[WB_W-1:0]};

  // Shared multiplier operand: pool size for range check, slot for offset
  assign mul_a = ctl.rmul ? MA_W'(n_slots) : MA_W'(slot);

  // Restoring divider step
  assign div_d = DV_W'(obj_size) << k_r;
  assign div_r = DV_W'(rem_r);

  // Word to write back
  always_comb begin
    if (ctl.apick) begin
      new_word = word_v | (WB'(1) << pick[WB_W-1:0]);
    end else begin
      new_word = word_v & ~(WB'(1) << q_r[WB_W-1:0]);
    end
  end

  assign we = (ctl.apick && pick[WB_W]) || (ctl.rwr && word_v[q_r[WB_W-1:0]]);

  // Read address per step
  always_comb begin
    rd_en   = ctl.afind || ctl.qfirst || ctl.qword || ctl.rtest;
    rd_addr = a_word;
    if (ctl.qfirst) begin
      rd_addr = s_word;
    end else if (ctl.qword) begin
      rd_addr = q_word;
    end else if (ctl.rtest) begin
      rd_addr = q_r[SI_W-1:WB_W];
    end
  end

  // Status back to the controller
  always_comb begin
    sts.a_cand     = a_found && (CW'(cnt_r) < n_ext);
    sts.r_in_range = P_W'(off_r) < prod_r;
    sts.div_last   = (k_r == '0);
    sts.r_aligned  = (rem_r == '0);
    sts.q_in_range = s_ext < n_ext;
    sts.q_hit      = pick[WB_W];
    sts.q_more     = q_found;
  end

  // Next values of the working registers
  always_comb begin
    status_nxt = status_r;
    next_nxt   = next_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    any_nxt    = any_r;
    full_nxt   = full_r;

    if (ctl.load) begin
      status_nxt = ST_OK;
      next_nxt   = '0;
    end

    if (ctl.afind && !sts.a_cand) begin
      status_nxt = ST_FULL;
    end

    if (ctl.apick) begin
      if (pick[WB_W]) begin
        any_nxt[addr_r]  = 1'b1;
        full_nxt[addr_r] = &new_word;
        cnt_nxt          = cnt_r + CNT_LW'(1);
      end else begin
        status_nxt = ST_FULL;
      end
    end

    if (ctl.apick || ctl.rmul) begin
      prod_nxt = P_W'(mul_a) * P_W'(obj_size);
    end

    if (ctl.rchk) begin
      if (!sts.r_in_range) begin
        status_nxt = ST_RANGE;
      end
      rem_nxt = off_r;
      q_nxt   = '0;
      k_nxt   = K_W'(SI_W - 1);
    end

    if (ctl.rdiv) begin
      if (div_r >= div_d) begin
        rem_nxt = OFF_W'(div_r - div_d);
        q_nxt   = {q_r[SI_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[SI_W-2:0], 1'b0};
      end
      k_nxt = k_r - K_W'(1);
    end

    if (ctl.rtest && !sts.r_aligned) begin
      status_nxt = ST_MISALIGNED;
    end

    if (ctl.rwr) begin
      if (word_v[q_r[WB_W-1:0]]) begin
        any_nxt[addr_r]  = |new_word;
        full_nxt[addr_r] = 1'b0;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_LW'(1);
        end
      end else begin
        status_nxt = ST_NOT_LIVE;
      end
    end

    if (ctl.clr) begin
      any_nxt  = '0;
      full_nxt = '0;
      cnt_nxt  = '0;
    end

    if (ctl.qfirst && !sts.q_in_range) begin
      next_nxt = n_slots;
    end

    if (ctl.qword) begin
      if (pick[WB_W]) begin
        next_nxt = CNT_W'(slot);
      end else if (!q_found) begin
        next_nxt = n_slots;
      end
    end

    if (ctl.qnext) begin
      next_nxt = pick[WB_W] ? CNT_W'(slot) : n_slots;
    end
  end

  // Control state: word flags and live count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r  <= '0;
      full_r <= '0;
      cnt_r  <= '0;
    end else begin
      any_r  <= any_nxt;
      full_r <= full_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      off_r <= in_offset;
      idx_r <= in_index;
    end
    status_r <= status_nxt;
    next_r   <= next_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    k_r      <= k_nxt;
  end

  // Bitmap memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
      addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr_r] <= new_word;
    end
  end

  // Result register toward the output channel
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= status_r;
      out_offset_r <= ((cmd_r == CMD_ALLOC) && (status_r == ST_OK)) ?
                      prod_r[OFF_W-1:0] : '0;
      out_next_r   <= next_r;
      out_live_r   <= CNT_W'(cnt_r);
    end
  end

  assign out_status = out_status_r;
  assign out_offset = out_offset_r;
  assign out_next   = out_next_r;
  assign out_live   = out_live_r;

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// First-fit slot allocator over a pool of fixed-size slots. Each input transfer carries
// a command in in_tuser (allocate, release by byte offset, clear, next-live query) and
// produces exactly one result transfer with a status, the allocated byte offset, the
// query answer and the live slot count. The live bitmap sits in a memory of 8-bit words
// with one read and one write port; per-word live and full flags in flip-flops steer the
// first-fit search and make the bitmap read as empty after reset or clear, so no
// clearing pass is needed. One item at a time is worked on. A release turns the byte
// offset into a slot number with a shift-subtract divider that produces one quotient
// bit per cycle. The result sits in an output register, so a new command is taken
// while the previous result waits.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int SLOTS            = SLOTS_DEF,
  parameter int MAX_OBJECT_BYTES = MAX_OBJ_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [19:0] byte_offset, [28:20] slot_index, [31:29] zero
  input  logic [31:0] in_tdata,
  // in_tuser: [1:0] cmd
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [2:0] status, [22:3] result_offset, [31:23] next_index,
  //            [40:32] live_total, [47:41] zero
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CNT_W-1:0]  slot_count_r, slot_count_nxt;
  logic [SIZE_W-1:0] object_size_r, object_size_nxt;
  logic [CNT_W-1:0]  n_eff;
  logic [SIZE_W-1:0] size_eff;
  logic              cfg_wr;

  bsa_ctl_t          ctl;
  bsa_sts_t          sts;
  logic [ST_W-1:0]   res_status;
  logic [OFF_W-1:0]  res_offset;
  logic [CNT_W-1:0]  res_next;
  logic [CNT_W-1:0]  res_live;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_comb begin
    slot_count_nxt  = slot_count_r;
    object_size_nxt = object_size_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        1'(REG_SLOT_COUNT):  slot_count_nxt  = cfg_pwdata[CNT_W-1:0];
        1'(REG_OBJECT_SIZE): object_size_nxt = cfg_pwdata[SIZE_W-1:0];
        default:             slot_count_nxt  = slot_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r  <= CNT_W'(256);
      object_size_r <= SIZE_W'(16);
    end else begin
      slot_count_r  <= slot_count_nxt;
      object_size_r <= object_size_nxt;
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr[2])
      1'(REG_SLOT_COUNT):  cfg_prdata = 32'(slot_count_r);
      1'(REG_OBJECT_SIZE): cfg_prdata = 32'(object_size_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Clamp the slot count to the pool and the size to 1..MAX_OBJECT_BYTES
  assign n_eff = (32'(slot_count_r) > 32'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_r;

  always_comb begin
    if (object_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(object_size_r) > 32'(MAX_OBJECT_BYTES)) begin
      size_eff = SIZE_W'(MAX_OBJECT_BYTES);
    end else begin
      size_eff = object_size_r;
    end
  end

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  bsa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (in_tuser),
    .in_offset  (in_tdata[OFF_W-1:0]),
    .in_index   (in_tdata[OFF_W+IDX_W-1:OFF_W]),
    .n_slots    (n_eff),
    .obj_size   (size_eff),
    .out_status (res_status),
    .out_offset (res_offset),
    .out_next   (res_next),
    .out_live   (res_live)
  );

  assign out_tdata = {7'd0, res_live, res_next, res_offset, res_status};

endmodule
